// File: rtl/pibp_pkg.sv
`default_nettype none
package pibp_pkg;
	localparam int DEF_ROWS = 1024;
	localparam int DEF_COLS = 4096;
	localparam int LIMB_W = 40;
	localparam int ACC_W = 64;
	localparam int VAL_W = 184;
	localparam int MOD_W = 256;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [1:0] CFG_MOD0 = 2'd0;
	localparam logic [1:0] CFG_MOD1 = 2'd1;
	localparam logic [1:0] CFG_MOD2 = 2'd2;
	localparam logic [1:0] CFG_MOD3 = 2'd3;

	typedef struct packed {
		logic [1:0]   op;
		logic [12:0]  slot;
		logic [159:0] query;
		logic [9:0]   row;
		logic [11:0]  col;
		logic [7:0]   data;
	} item_t;

	typedef struct packed {
		logic [11:0]           col;
		logic [3:0][ACC_W-1:0] acc;
	} rd_req_t;
endpackage
`default_nettype wire

// File: rtl/pibp_front.sv
`default_nettype none
module pibp_front #(
	parameter int ROWS = 1024,
	parameter int COLS = 4096
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire pibp_pkg::item_t in_item,
	output logic               item_valid,
	output pibp_pkg::item_t    item,
	input  wire logic          item_pop
);
	import pibp_pkg::*;

	localparam int SLOTS = ROWS * 8;

	item_t       buf_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        keep;
	logic        wr_en;

	always_comb begin
		case (in_item.op)
			KIND_LOAD: keep = 32'(in_item.slot) < 32'(SLOTS);
			KIND_BYTE: keep = (32'(in_item.row) < 32'(ROWS)) && (32'(in_item.col) < 32'(COLS));
			KIND_READ: keep = 1'b1;
			default:   keep = 1'b0;
		endcase
	end

	assign full       = cnt_q == 2'd2;
	assign wr_en      = push && !full && keep;
	assign item_valid = cnt_q != 2'd0;
	assign item       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_q <= !wr_q;
			end
			if (item_pop) begin
				rd_q <= !rd_q;
			end
			case ({wr_en, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/pibp_back.sv
`default_nettype none
module pibp_back #(
	parameter int ROWS = 1024,
	parameter int COLS = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            item_valid,
	input  wire pibp_pkg::item_t item,
	output logic                 item_pop,
	output logic                 req_valid,
	output pibp_pkg::rd_req_t    req,
	input  wire logic            req_ready
);
	import pibp_pkg::*;

	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int SLOT_AW = ROW_AW + 3;
	localparam int SLOTS = ROWS * 8;
	localparam logic [COL_AW:0] CLR_LAST = (COL_AW + 1)'(COLS - 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_LD   = 3'd2;
	localparam logic [2:0] S_PICK = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_RD   = 3'd5;

	logic [159:0]          q_mem [SLOTS];
	logic [MOD_W-1:0]      acc_mem [COLS];

	logic [2:0]            st_q;
	logic [COL_AW:0]       clr_q;
	logic [COL_AW-1:0]     col_q;
	logic [11:0]           rcol_q;
	logic                  rin_q;
	logic [ROW_AW-1:0]     row_q;
	logic [7:0]            bits_q;
	logic [3:0][ACC_W-1:0] sum_q;
	logic [159:0]          q_rd_q;
	logic [MOD_W-1:0]      acc_rd_q;

	logic [16:0]           row_x;
	logic [19:0]           slot_x;
	logic [20:0]           col_x;
	logic [2:0]            bsel;
	logic                  q_we;
	logic                  q_re;
	logic [SLOT_AW-1:0]    q_raddr;
	logic                  acc_we;
	logic [COL_AW-1:0]     acc_waddr;
	logic [MOD_W-1:0]      acc_wdata;
	logic                  acc_re;

	assign row_x  = 17'(item.row);
	assign slot_x = 20'(item.slot);
	assign col_x  = 21'(item.col);

	always_comb begin
		bsel = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (bits_q[i]) begin
				bsel = 3'(i);
			end
		end
	end

	always_comb begin
		item_pop  = 1'b0;
		q_we      = 1'b0;
		q_re      = 1'b0;
		q_raddr   = {row_q, bsel};
		acc_we    = 1'b0;
		acc_waddr = col_q;
		acc_wdata = '0;
		acc_re    = 1'b0;
		req_valid = 1'b0;
		req.col   = rcol_q;
		req.acc   = rin_q ? acc_rd_q : '0;
		case (st_q)
			S_CLR: begin
				acc_we    = 1'b1;
				acc_waddr = clr_q[COL_AW-1:0];
			end
			S_IDLE: begin
				item_pop = item_valid && (item.op != KIND_READ || req_ready);
				q_we     = item_pop && item.op == KIND_LOAD;
				acc_re   = item_pop && item.op != KIND_LOAD;
			end
			S_PICK: begin
				if (bits_q == 8'd0) begin
					acc_we    = 1'b1;
					acc_wdata = sum_q;
				end else begin
					q_re = 1'b1;
				end
			end
			S_RD: begin
				req_valid = 1'b1;
				acc_we    = rin_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[slot_x[SLOT_AW-1:0]] <= item.query;
		end
		if (q_re) begin
			q_rd_q <= q_mem[q_raddr];
		end
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		if (acc_re) begin
			acc_rd_q <= acc_mem[col_x[COL_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && item_pop) begin
			col_q  <= col_x[COL_AW-1:0];
			rcol_q <= item.col;
			rin_q  <= 32'(item.col) < 32'(COLS);
			row_q  <= row_x[ROW_AW-1:0];
		end
		if (st_q == S_LD) begin
			sum_q <= acc_rd_q;
		end else if (st_q == S_ADD) begin
			for (int i = 0; i < 4; i++) begin
				sum_q[i] <= sum_q[i] + ACC_W'(q_rd_q[i*LIMB_W +: LIMB_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLR;
			clr_q  <= '0;
			bits_q <= '0;
		end else begin
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_pop) begin
						bits_q <= item.data;
						case (item.op)
							KIND_BYTE: st_q <= S_LD;
							KIND_READ: st_q <= S_RD;
							default:   st_q <= S_IDLE;
						endcase
					end
				end
				S_LD: st_q <= S_PICK;
				S_PICK: begin
					if (bits_q == 8'd0) begin
						st_q <= S_IDLE;
					end else begin
						bits_q[bsel] <= 1'b0;
						st_q <= S_ADD;
					end
				end
				S_ADD: st_q <= S_PICK;
				S_RD: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/pibp_reduce.sv
`default_nettype none
module pibp_reduce (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	input  wire pibp_pkg::rd_req_t          req,
	output logic                            req_ready,
	input  wire logic [pibp_pkg::MOD_W-1:0] modulus,
	output logic                            res_valid,
	output logic [pibp_pkg::MOD_W-1:0]      res_value,
	output logic [11:0]                     res_col,
	output logic                            res_pzero,
	input  wire logic                       res_take
);
	import pibp_pkg::*;

	localparam logic [2:0] R_IDLE = 3'd0;
	localparam logic [2:0] R_C1   = 3'd1;
	localparam logic [2:0] R_C2   = 3'd2;
	localparam logic [2:0] R_C3   = 3'd3;
	localparam logic [2:0] R_PACK = 3'd4;
	localparam logic [2:0] R_DIV  = 3'd5;
	localparam logic [2:0] R_DONE = 3'd6;

	logic [2:0]            st_q;
	logic [3:0][ACC_W-1:0] a_q;
	logic [11:0]           col_q;
	logic                  pz_q;
	logic [MOD_W-1:0]      rem_q;
	logic [VAL_W-1:0]      v_q;
	logic [7:0]            cnt_q;
	logic                  res_valid_q;

	logic [MOD_W-1:0]      shifted;
	logic [MOD_W+1:0]      diff;
	logic                  out_free;

	assign shifted   = {rem_q[MOD_W-2:0], v_q[VAL_W-1]};
	assign diff      = {1'b0, rem_q[MOD_W-1], shifted} - {2'b00, modulus};
	assign out_free  = !res_valid_q || res_take;
	assign req_ready = st_q == R_IDLE;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		case (st_q)
			R_IDLE: begin
				a_q   <= req.acc;
				col_q <= req.col;
				pz_q  <= modulus == '0;
			end
			R_C1: begin
				a_q[1] <= a_q[1] + ACC_W'(a_q[0][ACC_W-1:LIMB_W]);
				a_q[0] <= ACC_W'(a_q[0][LIMB_W-1:0]);
			end
			R_C2: begin
				a_q[2] <= a_q[2] + ACC_W'(a_q[1][ACC_W-1:LIMB_W]);
				a_q[1] <= ACC_W'(a_q[1][LIMB_W-1:0]);
			end
			R_C3: begin
				a_q[3] <= a_q[3] + ACC_W'(a_q[2][ACC_W-1:LIMB_W]);
				a_q[2] <= ACC_W'(a_q[2][LIMB_W-1:0]);
			end
			R_PACK: begin
				v_q   <= {a_q[3], a_q[2][LIMB_W-1:0], a_q[1][LIMB_W-1:0], a_q[0][LIMB_W-1:0]};
				rem_q <= '0;
				cnt_q <= 8'(VAL_W);
			end
			R_DIV: begin
				rem_q <= diff[MOD_W+1] ? shifted : diff[MOD_W-1:0];
				v_q   <= {v_q[VAL_W-2:0], 1'b0};
				cnt_q <= cnt_q - 8'd1;
			end
			default: begin
			end
		endcase
		if (st_q == R_DONE && out_free) begin
			res_value <= rem_q;
			res_col   <= col_q;
			res_pzero <= pz_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= R_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (st_q == R_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				R_IDLE:  if (req_valid) st_q <= R_C1;
				R_C1:    st_q <= R_C2;
				R_C2:    st_q <= R_C3;
				R_C3:    st_q <= R_PACK;
				R_PACK:  st_q <= pz_q ? R_DONE : R_DIV;
				R_DIV:   if (cnt_q == 8'd1) st_q <= R_DONE;
				R_DONE:  if (out_free) st_q <= R_IDLE;
				default: st_q <= R_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/pir_bit_inner_product_mod_p.sv
// Column inner product of database bits with query elements, reduced mod p.
// Input queue: push/full. kind 0 stores a 160-bit query element at
// element_index, kind 1 adds the elements selected by db_byte at row into
// the accumulator of column, kind 2 reads out column and clears it.
// Result queue: empty/pop, one 256-bit result per kind 2 item, held until popped.
// Config: cfg_valid/cfg_ready (always ready), cfg_index 0..3 selects a
// 64-bit word of the modulus; write only while the block is idle.
// After reset the accumulators are swept to zero, one column per cycle;
// two items may be queued meanwhile, then full rises.
// Accumulate engine: a load is stored when taken; a byte reads its column,
// then a pick and an add per set bit (query RAM read per set bit), then a
// write back; a readout reads and clears (single accumulator RAM port).
// Readout: carry pass, then one restoring shift-subtract step per bit of
// the 184-bit sum (skipped for a zero modulus); one reduction at a time.
// A stalled result blocks only the reducer; loads and bytes keep flowing
// until a readout reaches the accumulate engine.
`default_nettype none
module pir_bit_inner_product_mod_p
	import pibp_pkg::*;
#(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [12:0] element_index,
	input  wire logic [39:0] query_limb0,
	input  wire logic [39:0] query_limb1,
	input  wire logic [39:0] query_limb2,
	input  wire logic [39:0] query_limb3,
	input  wire logic [9:0]  row,
	input  wire logic [11:0] column,
	input  wire logic [7:0]  db_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [63:0]      result_word0,
	output logic [63:0]      result_word1,
	output logic [63:0]      result_word2,
	output logic [63:0]      result_word3,
	output logic [11:0]      result_column,
	output logic             modulus_zero,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	item_t            in_item;
	item_t            item;
	logic             item_valid;
	logic             item_pop;
	rd_req_t          req;
	logic             req_valid;
	logic             req_ready;
	logic [63:0]      mod_q [4];
	logic [MOD_W-1:0] res_value;
	logic             res_valid;

	assign in_item.op    = kind;
	assign in_item.slot  = element_index;
	assign in_item.query = {query_limb3, query_limb2, query_limb1, query_limb0};
	assign in_item.row   = row;
	assign in_item.col   = column;
	assign in_item.data  = db_byte;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				mod_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MOD0: mod_q[0] <= cfg_data;
				CFG_MOD1: mod_q[1] <= cfg_data;
				CFG_MOD2: mod_q[2] <= cfg_data;
				CFG_MOD3: mod_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	pibp_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.item_valid(item_valid), .item(item), .item_pop(item_pop)
	);

	pibp_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item(item),
		.item_pop(item_pop), .req_valid(req_valid), .req(req), .req_ready(req_ready)
	);

	pibp_reduce u_reduce (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req(req),
		.req_ready(req_ready), .modulus({mod_q[3], mod_q[2], mod_q[1], mod_q[0]}),
		.res_valid(res_valid), .res_value(res_value), .res_col(result_column),
		.res_pzero(modulus_zero), .res_take(pop && res_valid)
	);

	assign empty        = !res_valid;
	assign result_word0 = res_value[63:0];
	assign result_word1 = res_value[127:64];
	assign result_word2 = res_value[191:128];
	assign result_word3 = res_value[255:192];
endmodule
`default_nettype wire
